/* rtl/scfa_pkg.sv */
package scfa_pkg;

  // Region geometry
  localparam int ADDR_BITS   = 20;
  localparam int IDX_W       = ADDR_BITS - 4;
  localparam int LINK_DEPTH  = 1 << IDX_W;
  localparam int OFF_W       = ADDR_BITS + 1;
  localparam int BSIZE_W     = 21;
  localparam int LIMIT_W     = 21;
  localparam int SUM_W       = ((OFF_W > BSIZE_W) ? OFF_W : BSIZE_W) + 1;

  // Size classes: 16 bytes up to 1 MiB
  localparam int NUM_CLASSES = 17;
  localparam int CLS_W       = 5;
  localparam int MAX_LOG2    = 20;
  localparam logic [31:0] MAX_BLOCK = 32'd1048576;
  localparam logic [SUM_W-1:0] REGION_SPAN = SUM_W'(1) << ADDR_BITS;
  localparam logic [BSIZE_W-1:0] MIN_BLOCK = BSIZE_W'(16);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_TOO_LARGE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EXHAUSTED,
    ST_TOO_LARGE
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic [CLS_W-1:0]   cls;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

  // Region settings seen by both parts
  typedef struct packed {
    logic [31:0]        base;
    logic [LIMIT_W-1:0] limit;
  } region_cfg_t;

endpackage

/* rtl/scfa_ram.sv */
module scfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/scfa_front.sv */
module scfa_front (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_req_type,
  input  logic [31:0]              in_block_size,
  input  logic [31:0]              in_block_address,
  input  scfa_pkg::region_cfg_t    cfg,
  input  logic                     q_full,
  output logic                     q_push,
  output scfa_pkg::cmd_t           q_data
);

  import scfa_pkg::*;

  logic [31:0]      size_m1;
  logic [31:0]      offset;
  logic [CLS_W-1:0] cls;

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Round size up to its class: position of the top set bit of size minus one
  always_comb begin
    size_m1 = (in_block_size == 32'd0) ? 32'd0 : in_block_size - 32'd1;
    cls     = '0;
    for (int k = 4; k < MAX_LOG2; k++) begin
      if (size_m1[k]) begin
        cls = CLS_W'(k - 3);
      end
    end
  end

  // Block index of a freed address within the region
  assign offset = in_block_address - cfg.base;

  // Build the command
  always_comb begin
    q_data.cls = cls;
    q_data.idx = offset[ADDR_BITS-1:4];
    if (in_block_size > MAX_BLOCK) begin
      q_data.kind = CMD_TOO_LARGE;
    end else if (in_req_type) begin
      q_data.kind = CMD_FREE;
    end else begin
      q_data.kind = CMD_ALLOC;
    end
  end

endmodule

/* rtl/scfa_queue.sv */
module scfa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scfa_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output scfa_pkg::cmd_t pop_data
);

  import scfa_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/scfa_back.sv */
module scfa_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scfa_pkg::region_cfg_t   cfg,
  input  logic                    cmd_valid,
  input  scfa_pkg::cmd_t          cmd,
  output logic                    cmd_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [31:0]             out_granted_address,
  output logic [1:0]              out_status
);

  import scfa_pkg::*;

  back_state_t        state_r, state_nxt;
  logic               head_valid_r [NUM_CLASSES];
  logic [IDX_W-1:0]   head_idx_r   [NUM_CLASSES];
  logic [OFF_W-1:0]   bump_r, bump_nxt;
  logic [CLS_W-1:0]   cur_cls_r, cur_cls_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_addr_r, out_addr_nxt;
  status_t            out_status_r, out_status_nxt;

  logic               head_wr;
  logic [CLS_W-1:0]   head_wr_cls;
  logic               head_wr_valid;
  logic [IDX_W-1:0]   head_wr_idx;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [IDX_W-1:0]   ram_rd_data;

  logic               out_free;
  logic [BSIZE_W-1:0] bsize;
  logic [SUM_W-1:0]   limit_eff;
  logic [SUM_W-1:0]   bump_end;
  logic [IDX_W-1:0]   pop_head;

  scfa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cmd.idx),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign bsize     = MIN_BLOCK << cmd.cls;
  assign limit_eff = (SUM_W'(cfg.limit) > REGION_SPAN) ? REGION_SPAN : SUM_W'(cfg.limit);
  assign bump_end  = SUM_W'(bump_r) + SUM_W'(bsize);
  assign pop_head  = head_idx_r[cur_cls_r];
  assign ram_rd_addr = head_idx_r[cmd.cls];
  assign ram_wr_data = head_valid_r[cmd.cls] ? head_idx_r[cmd.cls] : cmd.idx;

  // Sequence commands and form results
  always_comb begin
    state_nxt      = state_r;
    bump_nxt       = bump_r;
    cur_cls_nxt    = cur_cls_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    cmd_pop        = 1'b0;
    head_wr        = 1'b0;
    head_wr_cls    = cmd.cls;
    head_wr_valid  = 1'b1;
    head_wr_idx    = cmd.idx;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_FREE: begin
              // Push the block: link to old head, or to itself on an empty list
              ram_wr_en      = 1'b1;
              head_wr        = 1'b1;
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = 32'd0;
              out_status_nxt = ST_OK;
            end
            CMD_ALLOC: begin
              if (head_valid_r[cmd.cls]) begin
                // Fetch the head's link, finish in BK_POP once the output is free
                ram_rd_en   = 1'b1;
                cur_cls_nxt = cmd.cls;
                state_nxt   = BK_POP;
              end else if (bump_end <= limit_eff) begin
                bump_nxt       = bump_end[OFF_W-1:0];
                out_valid_nxt  = 1'b1;
                out_addr_nxt   = cfg.base + 32'(bump_r);
                out_status_nxt = ST_OK;
              end else begin
                out_valid_nxt  = 1'b1;
                out_addr_nxt   = 32'd0;
                out_status_nxt = ST_EXHAUSTED;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = 32'd0;
              out_status_nxt = ST_TOO_LARGE;
            end
          endcase
        end
      end
      BK_POP: begin
        if (out_free) begin
          // A self link marks the list end
          head_wr        = 1'b1;
          head_wr_cls    = cur_cls_r;
          head_wr_valid  = (ram_rd_data != pop_head);
          head_wr_idx    = ram_rd_data;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = cfg.base + (32'(pop_head) << 4);
          out_status_nxt = ST_OK;
          state_nxt      = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_wr) begin
        head_valid_r[head_wr_cls] <= head_wr_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_cls_r    <= cur_cls_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    if (head_wr && head_wr_valid) begin
      head_idx_r[head_wr_cls] <= head_wr_idx;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

endmodule

/* rtl/size_class_free_list_allocator.sv */
// Channel   Ports                                                 Direction
// input     in_valid, in_stall, in_req_type, in_block_size,       request in
//           in_block_address
// result    out_valid, out_stall, out_granted_address, out_status result out
// config    cfg_wr_en, cfg_index, cfg_wdata                       write in
//
// A pop from a class list goes through BK_IDLE and BK_POP, around the registered
// read of the link store; frees, bump allocations and errors finish in BK_IDLE of the back end.
// A two-entry queue sits between classification and the back end.
// Reset is synchronous; the link store needs no clearing and is usable at once.
// A stalled result holds in the output register while new requests queue up.
module size_class_free_list_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [31:0]                    in_block_size,
  input  logic [31:0]                    in_block_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_granted_address,
  output logic [1:0]                     out_status,
  input  logic                           cfg_wr_en,
  input  logic [scfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  import scfa_pkg::*;

  region_cfg_t cfg_r;
  logic        q_push;
  logic        q_full;
  cmd_t        q_in;
  logic        q_pop;
  logic        q_not_empty;
  cmd_t        q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base  <= 32'd0;
      cfg_r.limit <= LIMIT_W'(MAX_BLOCK);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REGION_BASE:  cfg_r.base  <= cfg_wdata;
        CFG_REGION_LIMIT: cfg_r.limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  scfa_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_block_size    (in_block_size),
    .in_block_address (in_block_address),
    .cfg              (cfg_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in)
  );

  scfa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  scfa_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd_valid           (q_not_empty),
    .cmd                 (q_out),
    .cmd_pop             (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

endmodule

/* test/size_class_free_list_allocator_test.sv */
`timescale 1ns / 1ps

import scfa_pkg::*;

typedef enum logic {
  REQ_ALLOC = 1'b0,
  REQ_FREE  = 1'b1
} req_kind_t;

// One expected response of the allocator
typedef struct packed {
  logic [31:0] addr;
  status_t     st;
} grant_t;

// A block handed out earlier and still held by the stimulus
typedef struct packed {
  logic [31:0] addr;
  logic [31:0] size;
} live_block_t;

class alloc_scoreboard;
  logic [31:0]       base;
  logic [LIMIT_W-1:0] limit;
  bit                head_valid [NUM_CLASSES];
  logic [IDX_W-1:0]  head_idx [NUM_CLASSES];
  logic [IDX_W-1:0]  next_link [LINK_DEPTH];
  logic [31:0]       bump;
  grant_t            grants_due [$];
  int                errors;
  int                n_requests;
  int                n_pops;
  int                n_bumps;
  int                n_frees;
  int                n_exhausted;
  int                n_too_large;

  function new();
    base  = '0;
    limit = LIMIT_W'(1048576);
    bump  = '0;
    foreach (head_valid[c]) begin
      head_valid[c] = 1'b0;
      head_idx[c]   = '0;
    end
    errors      = 0;
    n_requests  = 0;
    n_pops      = 0;
    n_bumps     = 0;
    n_frees     = 0;
    n_exhausted = 0;
    n_too_large = 0;
  endfunction

  function void set_region(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    if (idx == CFG_REGION_BASE) begin
      base = val;
    end else if (idx == CFG_REGION_LIMIT) begin
      limit = val[LIMIT_W-1:0];
    end
  endfunction

  function int pending();
    return grants_due.size();
  endfunction

  // Work out the response to an accepted request and advance the lists
  function grant_t note_request(req_kind_t rt, logic [31:0] sz, logic [31:0] ad);
    grant_t           g;
    int               c;
    logic [31:0]      bsz;
    logic [31:0]      span;
    logic [31:0]      usable;
    logic [31:0]      room;
    logic [31:0]      off;
    logic [IDX_W-1:0] h;
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] idx;
    g.addr = '0;
    g.st   = ST_OK;
    span   = 32'(1) << ADDR_BITS;
    n_requests++;
    if (sz > MAX_BLOCK) begin
      g.st = ST_TOO_LARGE;
      n_too_large++;
    end else begin
      // round up to the smallest power of two class, 16 bytes at least
      c = 0;
      while (c < NUM_CLASSES - 1 && (32'd16 << c) < sz) c++;
      bsz = 32'd16 << c;
      if (rt == REQ_ALLOC) begin
        if (head_valid[c]) begin
          // pop; a block linked to itself ends the list
          h  = head_idx[c];
          nx = next_link[h];
          if (nx == h) begin
            head_valid[c] = 1'b0;
          end else begin
            head_idx[c] = nx;
          end
          g.addr = base + (32'(h) << 4);
          n_pops++;
        end else begin
          usable = (32'(limit) < span) ? 32'(limit) : span;
          room   = (bump < usable) ? usable - bump : 32'd0;
          if (room < bsz) begin
            g.st = ST_EXHAUSTED;
            n_exhausted++;
          end else begin
            g.addr = base + bump;
            bump   = bump + bsz;
            n_bumps++;
          end
        end
      end else begin
        // push whatever address is given, no checks
        off            = (ad - base) & (span - 32'd1);
        idx            = off[ADDR_BITS-1:4];
        next_link[idx] = head_valid[c] ? head_idx[c] : idx;
        head_idx[c]    = idx;
        head_valid[c]  = 1'b1;
        n_frees++;
      end
    end
    grants_due.push_back(g);
    return g;
  endfunction

  // Compare one response transfer with the oldest expectation
  function void check_result(logic [31:0] addr, logic [1:0] st);
    grant_t g;
    if (grants_due.size() == 0) begin
      $error("unexpected response: granted_address %h, status %0d", addr, st);
      errors++;
    end else begin
      g = grants_due.pop_front();
      if (addr !== g.addr) begin
        $error("granted_address: expected %h, actual %h", g.addr, addr);
        errors++;
      end
      if (st !== g.st) begin
        $error("status: expected %0d, actual %0d", g.st, st);
        errors++;
      end
    end
  endfunction
endclass

module size_class_free_list_allocator_test;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_req_type = 1'b0;
  logic [31:0]          in_block_size = '0;
  logic [31:0]          in_block_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          out_granted_address;
  logic [1:0]           out_status;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REGION_BASE;
  logic [31:0]          cfg_wdata = '0;

  alloc_scoreboard sb = new();
  live_block_t     live [$];
  bit              steady = 1'b0;
  int              n_settings = 1;

  size_class_free_list_allocator u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_block_size       (in_block_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check each response transfer, then pick the next stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_granted_address, out_status);
      end
      out_stall <= !steady && ($urandom_range(99) < 29);
    end
  end

  // Offer one request and hold it until the transfer; maybe idle after it
  task automatic issue(input req_kind_t rt, input logic [31:0] sz, input logic [31:0] ad,
                       output grant_t g);
    in_valid         <= 1'b1;
    in_req_type      <= rt;
    in_block_size    <= sz;
    in_block_address <= ad;
    do @(posedge clk); while (in_stall);
    g = sb.note_request(rt, sz, ad);
    if (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Hold off until every response has come, then let the back end settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_region(input logic [31:0] b, input logic [LIMIT_W-1:0] lim);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_REGION_BASE;
    cfg_wdata <= b;
    @(posedge clk);
    sb.set_region(CFG_REGION_BASE, b);
    cfg_index <= CFG_REGION_LIMIT;
    cfg_wdata <= 32'(lim);
    @(posedge clk);
    sb.set_region(CFG_REGION_LIMIT, 32'(lim));
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Mostly allocate and free real blocks; the rest is stray frees and junk sizes
  task automatic random_item();
    grant_t      g;
    live_block_t b;
    int          r;
    int          k;
    int          pick;
    logic [31:0] sz;
    r = $urandom_range(99);
    if (r >= 45 && r < 80 && live.size() > 0) begin
      k = $urandom_range(live.size() - 1);
      b = live[k];
      live.delete(k);
      issue(REQ_FREE, b.size, b.addr, g);
    end else if (r < 80) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        sz = $urandom_range(64, 0);
      end else if (pick < 85) begin
        sz = $urandom_range(2048, 65);
      end else if (pick < 97) begin
        sz = $urandom_range(65536, 2049);
      end else begin
        sz = $urandom_range(1048576, 65537);
      end
      issue(REQ_ALLOC, sz, $urandom, g);
      if (g.st == ST_OK) begin
        live.push_back('{g.addr, sz});
      end
    end else if (r < 88) begin
      issue(REQ_FREE, $urandom_range(4096, 0), $urandom, g);
    end else if (r < 94) begin
      issue(req_kind_t'($urandom_range(1)), $urandom_range(32'hFFFF_FFFF, 32'h0010_0001),
            $urandom, g);
    end else begin
      issue(req_kind_t'($urandom_range(1)), $urandom, $urandom, g);
    end
    if (!steady && $urandom_range(99) < 3) begin
      wait_drain();
    end
  endtask

  initial begin
    grant_t g;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size rounding at the class edges, oversize and exhaustion
    issue(REQ_ALLOC, 32'd0, $urandom, g);
    issue(REQ_ALLOC, 32'd1, $urandom, g);
    issue(REQ_ALLOC, 32'd16, $urandom, g);
    issue(REQ_ALLOC, 32'd17, $urandom, g);
    issue(REQ_ALLOC, 32'd2048, $urandom, g);
    issue(REQ_ALLOC, 32'd2049, $urandom, g);
    issue(REQ_ALLOC, 32'd1048576, $urandom, g);
    issue(REQ_ALLOC, 32'd1048577, $urandom, g);
    issue(REQ_ALLOC, 32'hFFFF_FFFF, $urandom, g);
    issue(REQ_FREE, 32'h8000_0000, 32'hFFFF_FFFF, g);
    // push two, pop both; the last one links to itself
    issue(REQ_FREE, 32'd16, 32'h0000_0000, g);
    issue(REQ_FREE, 32'd0, 32'h0000_0010, g);
    issue(REQ_ALLOC, 32'd8, $urandom, g);
    issue(REQ_ALLOC, 32'd16, $urandom, g);
    issue(REQ_ALLOC, 32'd16, $urandom, g);
    // misaligned address freed twice
    issue(REQ_FREE, 32'd100, 32'hFFFF_FFF7, g);
    issue(REQ_FREE, 32'd100, 32'hFFFF_FFF7, g);
    issue(REQ_ALLOC, 32'd128, $urandom, g);
    issue(REQ_ALLOC, 32'd65, $urandom, g);
    issue(REQ_FREE, 32'd4096, 32'h0001_2345, g);
    issue(REQ_ALLOC, 32'd3000, $urandom, g);
    issue(REQ_ALLOC, 32'd524288, $urandom, g);
    issue(REQ_ALLOC, 32'd524288, $urandom, g);
    wait_drain();

    // random phases, each under its own region setting
    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: write_region(32'hFFFF_F000, 21'h1F_FFFF);
        2: write_region($urandom, LIMIT_W'($urandom_range(21'h1F_FFFF, 0)));
        3: write_region(32'h0000_0000, 21'h00_0000);
        4: write_region($urandom, 21'h10_0000);
        default: write_region(32'hFFFF_FFFF, LIMIT_W'($urandom_range(21'h1F_FFFF, 21'h0C_0000)));
      endcase
      steady <= (phase == 2);
      for (int n = 0; n < 140; n++) begin
        random_item();
      end
      wait_drain();
    end

    $display("Ran %0d requests under %0d region settings with random stalls on both sides.",
             sb.n_requests, n_settings);
    $display("Saw %0d list pops, %0d bump grants, %0d frees, %0d exhausted, %0d oversize.",
             sb.n_pops, sb.n_bumps, sb.n_frees, sb.n_exhausted, sb.n_too_large);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
